// File: hdl/u8d_pkg.sv
package u8d_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int REM_W  = 2;

    localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [BYTE_W-1:0] MASK_LEAD2     = 8'hE0;
    localparam logic [BYTE_W-1:0] TAG_LEAD2      = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3     = 8'hF0;
    localparam logic [BYTE_W-1:0] TAG_LEAD3      = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4     = 8'hF8;
    localparam logic [BYTE_W-1:0] TAG_LEAD4      = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_CONT      = 8'hC0;
    localparam logic [BYTE_W-1:0] TAG_CONT       = 8'h80;
    localparam logic [BYTE_W-1:0] PAY_LEAD2      = 8'h1F;
    localparam logic [BYTE_W-1:0] PAY_LEAD3      = 8'h0F;
    localparam logic [BYTE_W-1:0] PAY_LEAD4      = 8'h07;
    localparam logic [BYTE_W-1:0] PAY_CONT       = 8'h3F;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eot;
        logic            last;
    } res_t;

    typedef struct packed {
        logic [1:0]       n_res;
        res_t             res0;
        res_t             res1;
        logic [CP_W-1:0]  acc_next;
        logic [REM_W-1:0] rem_next;
    } dec_t;

endpackage

// File: hdl/u8d_decode.sv
module u8d_decode
    import u8d_pkg::*;
(
    input  logic [BYTE_W-1:0] in_byte,
    input  logic [CP_W-1:0]   acc,
    input  logic [REM_W-1:0]  rem,
    output dec_t              dec
);

    // lead-position decode of the byte
    logic             lead_emit;
    logic             lead_load;
    res_t             lead_res;
    logic [CP_W-1:0]  lead_acc;
    logic [REM_W-1:0] lead_rem;
    logic             is_cont;
    logic [CP_W-1:0]  acc_shift;
    logic [REM_W-1:0] rem_dec;

    always_comb
    begin
        lead_emit = 1'b0;
        lead_load = 1'b0;
        lead_res  = '0;
        lead_acc  = acc;
        lead_rem  = '0;
        if (in_byte == '0)
        begin
            lead_emit    = 1'b1;
            lead_res.eot = 1'b1;
        end
        else if (!in_byte[BYTE_W-1])
        begin
            lead_emit   = 1'b1;
            lead_res.cp = CP_W'(in_byte);
        end
        else if ((in_byte & MASK_LEAD2) == TAG_LEAD2)
        begin
            lead_load = 1'b1;
            lead_acc  = CP_W'(in_byte & PAY_LEAD2);
            lead_rem  = 2'd1;
        end
        else if ((in_byte & MASK_LEAD3) == TAG_LEAD3)
        begin
            lead_load = 1'b1;
            lead_acc  = CP_W'(in_byte & PAY_LEAD3);
            lead_rem  = 2'd2;
        end
        else if ((in_byte & MASK_LEAD4) == TAG_LEAD4)
        begin
            lead_load = 1'b1;
            lead_acc  = CP_W'(in_byte & PAY_LEAD4);
            lead_rem  = 2'd3;
        end
        else
        begin
            lead_emit   = 1'b1;
            lead_res.cp = REPLACEMENT_CP;
        end
    end

    assign is_cont   = (in_byte & MASK_CONT) == TAG_CONT;
    assign acc_shift = {acc[CP_W-7:0], in_byte[5:0]};
    assign rem_dec   = rem - 2'd1;

    always_comb
    begin
        dec          = '0;
        dec.acc_next = acc;
        dec.rem_next = rem;
        if (rem != '0)
        begin
            if (is_cont)
            begin
                dec.acc_next = acc_shift;
                dec.rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    dec.n_res     = 2'd1;
                    dec.res0.cp   = acc_shift;
                    dec.res0.last = 1'b1;
                end
            end
            else
            begin
                // broken sequence: replacement, then the byte again as a lead
                dec.res0.cp   = REPLACEMENT_CP;
                dec.acc_next  = lead_load ? lead_acc : acc;
                dec.rem_next  = lead_rem;
                if (lead_emit)
                begin
                    dec.n_res     = 2'd2;
                    dec.res1      = lead_res;
                    dec.res1.last = 1'b1;
                end
                else
                begin
                    dec.n_res     = 2'd1;
                    dec.res0.last = 1'b1;
                end
            end
        end
        else
        begin
            dec.acc_next = lead_load ? lead_acc : acc;
            dec.rem_next = lead_rem;
            if (lead_emit)
            begin
                dec.n_res     = 2'd1;
                dec.res0      = lead_res;
                dec.res0.last = 1'b1;
            end
        end
    end

endmodule

// File: hdl/u8d_result_queue.sv
module u8d_result_queue
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  res_t       push0,
    input  res_t       push1,
    output logic       room2,
    output logic       cp_valid,
    input  logic       cp_ready,
    output res_t       head
);

    res_t       entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign cp_valid = count_reg != '0;
    assign head     = entry_reg[rd_ptr_reg];
    assign room2    = count_reg <= 3'd2;
    assign pop      = cp_valid && cp_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/utf8_codepoint_decoder_core.sv
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------
// byte in   | byte_valid / byte_ready    | in_byte[7:0]
// result    | cp_valid / cp_ready        | code_point[20:0], end_of_text, last_of_run
//
// one byte per cycle sustained while the queue has two free entries; an item is
// registered in the input register and decoded from it, and its results enter
// a four-entry result queue, which offers a result once it has been written;
// a byte that yields two results fills two entries and leaves in two transfers; the input
// register waits while the queue has fewer than two free entries
// rst_n clears the decode state (awaiting a lead byte) and empties the queue
module utf8_codepoint_decoder_core
    import u8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              cp_valid,
    input  logic              cp_ready,
    output logic [CP_W-1:0]   code_point,
    output logic              end_of_text,
    output logic              last_of_run
);

    // input register
    logic              hold_valid_reg;
    logic              hold_valid_next;
    logic [BYTE_W-1:0] hold_byte_reg;

    // decode state
    logic [CP_W-1:0]   acc_reg;
    logic [CP_W-1:0]   acc_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;

    dec_t              dec;
    logic              room2;
    logic              fire;
    logic [1:0]        push_n;
    res_t              head;

    // decode the held byte only when the queue can absorb two results
    assign fire       = hold_valid_reg && room2;
    assign byte_ready = !hold_valid_reg || fire;
    assign push_n     = fire ? dec.n_res : 2'd0;

    u8d_decode u_decode
    (
        .in_byte (hold_byte_reg),
        .acc     (acc_reg),
        .rem     (rem_reg),
        .dec     (dec)
    );

    u8d_result_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_n   (push_n),
        .push0    (dec.res0),
        .push1    (dec.res1),
        .room2    (room2),
        .cp_valid (cp_valid),
        .cp_ready (cp_ready),
        .head     (head)
    );

    assign code_point  = head.cp;
    assign end_of_text = head.eot;
    assign last_of_run = head.last;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        if (byte_ready)
        begin
            hold_valid_next = byte_valid;
        end
        if (fire)
        begin
            acc_next = dec.acc_next;
            rem_next = dec.rem_next;
        end
    end

    // payload register, loaded on each accepted item
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            hold_byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            acc_reg        <= '0;
            rem_reg        <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            acc_reg        <= acc_next;
            rem_reg        <= rem_next;
        end
    end

endmodule
